/* sv/csc_pkg.sv */
// Shared widths, constants and beat types for the circle pair collision block.
package csc_pkg;

  // Coordinate format
  localparam int CW        = 32;
  localparam int FRAC_BITS = 16;
  localparam int BIAS_W    = 17;
  localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(((1 << FRAC_BITS) + 5) / 10);

  // Internal widths
  localparam int MW   = CW + 1;       // center offset magnitude
  localparam int SQW  = 2 * MW;       // full squared distance
  localparam int RADW = 2 * CW;       // squared distance when overlapping
  localparam int SW   = 2 * CW + 1;   // contact scale term and contact divisor
  localparam int SLO  = CW + 1;       // low slice of the scale term
  localparam int NUMW = CW + SW;      // divider numerator
  localparam int QW   = CW + 1;       // quotient bits kept by the divider
  localparam int REMW = SW;           // divider remainder and divisor

  // Pipeline depth: front end, square root, normal setup, divider, output
  localparam int FRONT   = 6;
  localparam int LATENCY = FRONT + CW + 2 + QW + 1;

  typedef struct packed {
    logic signed [CW-1:0] first_center_x;
    logic signed [CW-1:0] first_center_y;
    logic        [CW-2:0] first_radius;
    logic signed [CW-1:0] second_center_x;
    logic signed [CW-1:0] second_center_y;
    logic        [CW-2:0] second_radius;
  } in_t;

  typedef struct packed {
    logic                 overlap;
    logic signed [CW-1:0] normal_x;
    logic signed [CW-1:0] normal_y;
    logic signed [CW-1:0] contact_x;
    logic signed [CW-1:0] contact_y;
  } out_t;

  // Per-item data that rides along the pipeline
  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic [CW-1:0]        rt;
    logic [CW-1:0]        mx;
    logic [CW-1:0]        my;
    logic                 nx;
    logic                 ny;
    logic                 r1_lt_r2;
    logic                 overlap;
    logic                 contained;
    logic                 sn;
    logic                 div_zero;
    logic [NUMW-1:0]      num_cx;
    logic [NUMW-1:0]      num_cy;
    logic [SW-1:0]        den_c;
  } side_t;

endpackage

/* sv/csc_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with side data in step.
module csc_sqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [csc_pkg::RADW-1:0] rad,
  input  csc_pkg::side_t         side_in,
  output logic [csc_pkg::CW-1:0] root,
  output csc_pkg::side_t         side_out
);

  localparam int N  = csc_pkg::CW;
  localparam int RW = csc_pkg::CW + 2;
  localparam int TW = csc_pkg::CW + 4;

  logic [RW-1:0]            rem_r  [N];
  logic [N-1:0]             root_r [N];
  logic [csc_pkg::RADW-1:0] rad_r  [N];
  csc_pkg::side_t           side_r [N];

  logic [RW-1:0]            rem_i  [N];
  logic [N-1:0]             root_i [N];
  logic [csc_pkg::RADW-1:0] rad_i  [N];
  csc_pkg::side_t           side_i [N];
  logic [TW-1:0]            t      [N];
  logic [TW-1:0]            trial  [N];
  logic                     ge     [N];

  // Stage inputs and the trial subtract of each stage
  always_comb begin
    rem_i[0]  = '0;
    root_i[0] = '0;
    rad_i[0]  = rad;
    side_i[0] = side_in;
    for (int k = 1; k < N; k++) begin
      rem_i[k]  = rem_r[k-1];
      root_i[k] = root_r[k-1];
      rad_i[k]  = rad_r[k-1];
      side_i[k] = side_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      t[k]     = {rem_i[k], rad_i[k][csc_pkg::RADW-1 -: 2]};
      trial[k] = TW'({root_i[k], 2'b01});
      ge[k]    = t[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= ge[k] ? RW'(t[k] - trial[k]) : RW'(t[k]);
        root_r[k] <= {root_i[k][N-2:0], ge[k]};
        rad_r[k]  <= {rad_i[k][csc_pkg::RADW-3:0], 2'b00};
        side_r[k] <= side_i[k];
      end
    end
  end

  assign root     = root_r[N-1];
  assign side_out = side_r[N-1];

endmodule

/* sv/csc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module csc_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [csc_pkg::NUMW-1:0] num,
  input  logic [csc_pkg::REMW-1:0] den,
  output logic [csc_pkg::QW-1:0]   quo,
  output logic                     ovf
);

  localparam int N  = csc_pkg::QW;
  localparam int RW = csc_pkg::REMW;

  logic [RW-1:0] rem_r [N];
  logic [N-1:0]  q_r   [N];
  logic [N-1:0]  lo_r  [N];
  logic [RW-1:0] dv_r  [N];
  logic          ov_r  [N];

  logic [RW-1:0] rem_i [N];
  logic [N-1:0]  q_i   [N];
  logic [N-1:0]  lo_i  [N];
  logic [RW-1:0] dv_i  [N];
  logic          ov_i  [N];
  logic [RW:0]   t     [N];
  logic          ge    [N];

  // Quotient of 2^N or more is flagged up front; the steps then fill the low bits
  always_comb begin
    rem_i[0] = RW'(num[csc_pkg::NUMW-1:N]);
    q_i[0]   = '0;
    lo_i[0]  = num[N-1:0];
    dv_i[0]  = den;
    ov_i[0]  = RW'(num[csc_pkg::NUMW-1:N]) >= den;
    for (int k = 1; k < N; k++) begin
      rem_i[k] = rem_r[k-1];
      q_i[k]   = q_r[k-1];
      lo_i[k]  = lo_r[k-1];
      dv_i[k]  = dv_r[k-1];
      ov_i[k]  = ov_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      t[k]  = {rem_i[k], lo_i[k][N-1]};
      ge[k] = t[k] >= {1'b0, dv_i[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= ge[k] ? RW'(t[k] - {1'b0, dv_i[k]}) : RW'(t[k]);
        q_r[k]   <= {q_i[k][N-2:0], ge[k]};
        lo_r[k]  <= {lo_i[k][N-2:0], 1'b0};
        dv_r[k]  <= dv_i[k];
        ov_r[k]  <= ov_i[k];
      end
    end
  end

  assign quo = q_r[N-1];
  assign ovf = ov_r[N-1];

endmodule

/* sv/circle_pair_collision.sv */
// Circle pair collision: strict overlap test with penetration normal and contact point.
//
// Usage:
//   pair channel (pair_valid/pair_ready/pair) takes one beat per circle pair.
//   hit channel (hit_valid/hit_ready/hit) returns one beat per pair, in order.
//   bias_we/bias_data writes the normal bias register (Q1.16, 17 bits); write
//   it only while no beat is in flight.
// Pipeline from accepted pair beat to hit beat: 6 front-end stages
//   (offsets, squares, compares, contact numerators), 32 square-root stages,
//   2 normal setup stages, 33 divider stages and the output register.
// Throughput: one beat per cycle while hit_ready does not stall; every stage is a
//   register, and the four dividers run side by side, one quotient bit per stage.
// Reset: rst (synchronous) empties the pipeline and loads the bias with
//   round(0.1 * 2^16) = 6554.
// Stall: while a hit beat waits for hit_ready the whole pipeline holds and
//   pair_ready is low; nothing is lost or repeated.
module circle_pair_collision (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pair_valid,
  output logic                       pair_ready,
  input  csc_pkg::in_t               pair,
  output logic                       hit_valid,
  input  logic                       hit_ready,
  output csc_pkg::out_t              hit,
  input  logic                       bias_we,
  input  logic [csc_pkg::BIAS_W-1:0] bias_data
);

  localparam int CW  = csc_pkg::CW;
  localparam int MW  = csc_pkg::MW;
  localparam int SW  = csc_pkg::SW;
  localparam int SLO = csc_pkg::SLO;
  localparam int QW  = csc_pkg::QW;
  localparam int LAT = csc_pkg::LATENCY;

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW+2:0] SUM_MAX = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [CW+2:0] SUM_MIN = {4'b1111, {(CW-1){1'b0}}};

  logic                       en;
  logic [LAT-1:0]             v;
  logic [csc_pkg::BIAS_W-1:0] bias;

  // Global advance: the output register frees up or is empty
  assign en         = !v[LAT-1] || hit_ready;
  assign pair_ready = en;
  assign hit_valid  = v[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      bias <= csc_pkg::BIAS_RESET;
    end else begin
      if (en) v <= {v[LAT-2:0], pair_valid};
      if (bias_we) bias <= bias_data;
    end
  end

  // Stage 1: center offsets, radius sum and difference
  logic signed [CW:0] x1e, y1e, x2e, y2e;
  logic               nx_c, ny_c;
  logic [MW-1:0]      mx_c, my_c;

  always_comb begin
    x1e  = {pair.first_center_x[CW-1], pair.first_center_x};
    y1e  = {pair.first_center_y[CW-1], pair.first_center_y};
    x2e  = {pair.second_center_x[CW-1], pair.second_center_x};
    y2e  = {pair.second_center_y[CW-1], pair.second_center_y};
    nx_c = pair.second_center_x < pair.first_center_x;
    ny_c = pair.second_center_y < pair.first_center_y;
    mx_c = nx_c ? MW'(x1e - x2e) : MW'(x2e - x1e);
    my_c = ny_c ? MW'(y1e - y2e) : MW'(y2e - y1e);
  end

  csc_pkg::side_t s1, s2, s3, s4, s5, s6;
  csc_pkg::side_t s1_next, s2_next, s3_next, s4_next, s6_next;
  logic [MW-1:0]   s1_mx, s1_my;
  logic [CW-2:0]   s1_r1, s1_r2, s1_diff;

  always_comb begin
    s1_next          = '0;
    s1_next.x1       = pair.first_center_x;
    s1_next.y1       = pair.first_center_y;
    s1_next.x2       = pair.second_center_x;
    s1_next.y2       = pair.second_center_y;
    s1_next.rt       = CW'(pair.first_radius) + CW'(pair.second_radius);
    s1_next.nx       = nx_c;
    s1_next.ny       = ny_c;
    s1_next.r1_lt_r2 = pair.first_radius < pair.second_radius;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1      <= s1_next;
      s1_mx   <= mx_c;
      s1_my   <= my_c;
      s1_r1   <= pair.first_radius;
      s1_r2   <= pair.second_radius;
      s1_diff <= (pair.first_radius > pair.second_radius) ?
                 pair.first_radius - pair.second_radius :
                 pair.second_radius - pair.first_radius;
    end
  end

  // Stage 2: squares
  logic [2*MW-1:0] s2_mx2, s2_my2;
  logic [2*CW-1:0] s2_rt2;
  logic [2*CW-3:0] s2_dd2, s2_r1sq, s2_r2sq;

  always_comb begin
    s2_next    = s1;
    s2_next.mx = s1_mx[CW-1:0];
    s2_next.my = s1_my[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2      <= s2_next;
      s2_mx2  <= s1_mx * s1_mx;
      s2_my2  <= s1_my * s1_my;
      s2_rt2  <= s1.rt * s1.rt;
      s2_dd2  <= s1_diff * s1_diff;
      s2_r1sq <= s1_r1 * s1_r1;
      s2_r2sq <= s1_r2 * s1_r2;
    end
  end

  // Stage 3: squared distance, overlap and containment tests
  logic [csc_pkg::SQW-1:0]  d2_c;
  logic [SW-1:0]            s3_p;
  logic [2*CW-3:0]          s3_q;
  logic [csc_pkg::RADW-1:0] s3_d2;

  assign d2_c = csc_pkg::SQW'(s2_mx2) + csc_pkg::SQW'(s2_my2);

  always_comb begin
    s3_next           = s2;
    s3_next.overlap   = d2_c < csc_pkg::SQW'(s2_rt2);
    s3_next.contained = d2_c <= csc_pkg::SQW'(s2_dd2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3    <= s3_next;
      s3_p  <= SW'(s2_r1sq) + SW'(d2_c[csc_pkg::RADW-1:0]);
      s3_q  <= s2_r2sq;
      s3_d2 <= d2_c[csc_pkg::RADW-1:0];
    end
  end

  // Stage 4: contact scale term and divisor
  logic [SW-1:0]            s4_s;
  logic [csc_pkg::RADW-1:0] s4_d2;
  logic                     sn_c;

  assign sn_c = s3_p < SW'(s3_q);

  always_comb begin
    s4_next       = s3;
    s4_next.sn    = sn_c;
    s4_next.den_c = {s3_d2, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4    <= s4_next;
      s4_s  <= sn_c ? SW'(s3_q) - s3_p : s3_p - SW'(s3_q);
      s4_d2 <= s3_d2;
    end
  end

  // Stage 5: contact numerator partial products
  logic [CW+SLO-1:0]    s5_xlo, s5_ylo;
  logic [CW+SW-SLO-1:0] s5_xhi, s5_yhi;
  logic [csc_pkg::RADW-1:0] s5_d2;

  always_ff @(posedge clk) begin
    if (en) begin
      s5     <= s4;
      s5_xlo <= s4.mx * s4_s[SLO-1:0];
      s5_xhi <= s4.mx * s4_s[SW-1:SLO];
      s5_ylo <= s4.my * s4_s[SLO-1:0];
      s5_yhi <= s4.my * s4_s[SW-1:SLO];
      s5_d2  <= s4_d2;
    end
  end

  // Stage 6: contact numerators
  logic [csc_pkg::RADW-1:0] s6_d2;

  always_comb begin
    s6_next        = s5;
    s6_next.num_cx = csc_pkg::NUMW'(s5_xlo) + (csc_pkg::NUMW'(s5_xhi) << SLO);
    s6_next.num_cy = csc_pkg::NUMW'(s5_ylo) + (csc_pkg::NUMW'(s5_yhi) << SLO);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6    <= s6_next;
      s6_d2 <= s5_d2;
    end
  end

  // Distance
  logic [CW-1:0]  root;
  csc_pkg::side_t sq_side;

  csc_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad      (s6_d2),
    .side_in  (s6),
    .root     (root),
    .side_out (sq_side)
  );

  // Normal setup: divisor, depth, then numerators
  csc_pkg::side_t t1, t2, t1_next;
  logic [CW:0]     t1_div, t2_div;
  logic [CW-1:0]   t1_dep;
  logic [2*CW-1:0] t2_pnx, t2_pny;
  logic [CW:0]     div_c;

  assign div_c = (CW+1)'(root) + (CW+1)'(bias);

  always_comb begin
    t1_next          = sq_side;
    t1_next.div_zero = div_c == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1     <= t1_next;
      t1_div <= div_c;
      t1_dep <= sq_side.rt - root;
      t2     <= t1;
      t2_div <= t1_div;
      t2_pnx <= t1_dep * t1.mx;
      t2_pny <= t1_dep * t1.my;
    end
  end

  // Four dividers in lockstep
  logic [QW-1:0] q_nx, q_ny, q_cx, q_cy;
  logic          o_nx, o_ny, o_cx, o_cy;

  csc_div u_div_nx (
    .clk (clk), .en (en),
    .num (csc_pkg::NUMW'(t2_pnx)), .den (csc_pkg::REMW'(t2_div)),
    .quo (q_nx), .ovf (o_nx)
  );

  csc_div u_div_ny (
    .clk (clk), .en (en),
    .num (csc_pkg::NUMW'(t2_pny)), .den (csc_pkg::REMW'(t2_div)),
    .quo (q_ny), .ovf (o_ny)
  );

  csc_div u_div_cx (
    .clk (clk), .en (en),
    .num (t2.num_cx), .den (t2.den_c),
    .quo (q_cx), .ovf (o_cx)
  );

  csc_div u_div_cy (
    .clk (clk), .en (en),
    .num (t2.num_cy), .den (t2.den_c),
    .quo (q_cy), .ovf (o_cy)
  );

  // Side data delay matching the dividers
  csc_pkg::side_t sd [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= t2;
      for (int k = 1; k < QW; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // Normal saturation from sign and magnitude
  function automatic logic signed [CW-1:0] sat_norm(input logic neg, input logic ovf,
                                                    input logic [QW-1:0] q);
    logic [QW-1:0] lim;
    lim = QW'(1) << (CW-1);
    if (!neg) begin
      return (ovf || q >= lim) ? MAXV : CW'(q);
    end
    return (ovf || q > lim) ? MINV : -CW'(q);
  endfunction

  // Contact: first center plus signed offset, saturated
  function automatic logic signed [CW-1:0] sat_cont(input logic signed [CW-1:0] base,
                                                    input logic neg, input logic ovf,
                                                    input logic [QW-1:0] q);
    logic signed [CW+2:0] b_e;
    logic signed [CW+2:0] q_e;
    logic signed [CW+2:0] sum;
    b_e = {{3{base[CW-1]}}, base};
    q_e = {2'b00, q};
    sum = neg ? b_e - q_e : b_e + q_e;
    if (ovf) begin
      return neg ? MINV : MAXV;
    end
    if (sum > SUM_MAX) return MAXV;
    if (sum < SUM_MIN) return MINV;
    return sum[CW-1:0];
  endfunction

  // Output register
  csc_pkg::out_t  hit_next;
  csc_pkg::side_t sl;

  always_comb begin
    sl       = sd[QW-1];
    hit_next = '0;
    if (sl.overlap) begin
      hit_next.overlap = 1'b1;
      if (!sl.div_zero) begin
        hit_next.normal_x = sat_norm(sl.nx, o_nx, q_nx);
        hit_next.normal_y = sat_norm(sl.ny, o_ny, q_ny);
      end
      if (sl.contained) begin
        hit_next.contact_x = sl.r1_lt_r2 ? sl.x1 : sl.x2;
        hit_next.contact_y = sl.r1_lt_r2 ? sl.y1 : sl.y2;
      end else if (sl.den_c != '0) begin
        hit_next.contact_x = sat_cont(sl.x1, sl.nx ^ sl.sn, o_cx, q_cx);
        hit_next.contact_y = sat_cont(sl.y1, sl.ny ^ sl.sn, o_cy, q_cy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
    end
  end

endmodule

/* sv/csc_check.sv */
// Port-level checker for the circle pair collision block, bound to the top level.
module csc_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       pair_valid,
  input logic                       pair_ready,
  input csc_pkg::in_t               pair,
  input logic                       hit_valid,
  input logic                       hit_ready,
  input csc_pkg::out_t              hit
);

  // A stalled hit beat holds
  assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_ready |=> hit_valid && $stable(hit))
    else $error("hit beat changed while stalled");

  // A waiting pair beat holds
  assert property (@(posedge clk) disable iff (rst)
    pair_valid && !pair_ready |=> pair_valid && $stable(pair))
    else $error("pair beat changed while waiting");

  // Input is taken exactly when the output side can move
  assert property (@(posedge clk) disable iff (rst)
    pair_ready == (!hit_valid || hit_ready))
    else $error("pair_ready does not follow output stall");

  // A miss carries all-zero vectors
  assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit.overlap |->
      hit.normal_x == '0 && hit.normal_y == '0 &&
      hit.contact_x == '0 && hit.contact_y == '0)
    else $error("miss beat with nonzero fields");

  // Reset empties the pipeline
  assert property (@(posedge clk)
    rst |=> !hit_valid)
    else $error("hit_valid after reset");

endmodule

bind circle_pair_collision csc_check u_check (.*);
